// File: design/rabi_pkg.sv
`default_nettype none
package rabi_pkg;

	localparam int QUEUE_DEPTH = 2;
	localparam int DIV_STEPS = 32;
	localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic signed [31:0] start_x;
		logic signed [31:0] start_y;
		logic signed [31:0] start_z;
		logic signed [31:0] dir_x;
		logic signed [31:0] dir_y;
		logic signed [31:0] dir_z;
		logic signed [31:0] box_min_x;
		logic signed [31:0] box_min_y;
		logic signed [31:0] box_min_z;
		logic signed [31:0] box_max_x;
		logic signed [31:0] box_max_y;
		logic signed [31:0] box_max_z;
	} in_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] hit_x;
		logic signed [31:0] hit_y;
		logic signed [31:0] hit_z;
	} out_t;

	// one slab plane: sign and overflow of the quotient, dividend split for the divider
	typedef struct packed {
		logic        neg;
		logic        ovf;
		logic [16:0] rem0;
		logic [31:0] num_lo;
	} corner_t;

	typedef struct packed {
		logic signed [31:0] start;
		logic signed [31:0] dir;
		logic [31:0]        dmag;
		logic               zero;
		logic               in_slab;
		corner_t            lo;
		corner_t            hi;
	} axis_t;

	typedef struct packed {
		axis_t [2:0] ax;
	} item_t;

	// saturating signed slab parameter from quotient magnitude
	function automatic logic signed [31:0] sat_param(input logic [31:0] q, input logic neg,
			input logic ovf);
		logic signed [31:0] r;
		if (neg) begin
			if (ovf || q > 32'h8000_0000) r = Q_MIN;
			else r = -$signed(q);
		end else begin
			if (ovf || q[31]) r = Q_MAX;
			else r = $signed(q);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// File: design/rabi_front.sv
`default_nettype none
module rabi_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	input  wire rabi_pkg::in_t  req,
	input  wire logic           full,
	output logic                push,
	output rabi_pkg::item_t     item
);

	logic           valid_s1;
	rabi_pkg::in_t  req_s1;
	logic           accept;

	logic signed [31:0] s  [3];
	logic signed [31:0] d  [3];
	logic signed [31:0] lo [3];
	logic signed [31:0] hi [3];
	logic signed [32:0] dlo [3];
	logic signed [32:0] dhi [3];
	logic [32:0]        mlo [3];
	logic [32:0]        mhi [3];
	logic [31:0]        dm  [3];

	assign busy   = valid_s1 && full;
	assign push   = valid_s1 && !full;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
	end

	always_comb begin
		s[0]  = req_s1.start_x;   s[1]  = req_s1.start_y;   s[2]  = req_s1.start_z;
		d[0]  = req_s1.dir_x;     d[1]  = req_s1.dir_y;     d[2]  = req_s1.dir_z;
		lo[0] = req_s1.box_min_x; lo[1] = req_s1.box_min_y; lo[2] = req_s1.box_min_z;
		hi[0] = req_s1.box_max_x; hi[1] = req_s1.box_max_y; hi[2] = req_s1.box_max_z;
		for (int i = 0; i < 3; i++) begin
			dlo[i] = 33'(lo[i]) - 33'(s[i]);
			dhi[i] = 33'(hi[i]) - 33'(s[i]);
			mlo[i] = dlo[i][32] ? 33'(-dlo[i]) : 33'(dlo[i]);
			mhi[i] = dhi[i][32] ? 33'(-dhi[i]) : 33'(dhi[i]);
			dm[i]  = d[i][31] ? 32'(-d[i]) : 32'(d[i]);
			item.ax[i].start         = s[i];
			item.ax[i].dir           = d[i];
			item.ax[i].dmag          = dm[i];
			item.ax[i].zero          = (d[i] == 32'sd0);
			item.ax[i].in_slab       = (lo[i] <= s[i]) && (s[i] <= hi[i]);
			// dividend is |diff| * 2^16; upper 17 bits seed the remainder
			item.ax[i].lo.neg        = dlo[i][32] ^ d[i][31];
			item.ax[i].lo.rem0       = mlo[i][32:16];
			item.ax[i].lo.num_lo     = {mlo[i][15:0], 16'h0000};
			item.ax[i].lo.ovf        = {15'd0, mlo[i][32:16]} >= dm[i];
			item.ax[i].hi.neg        = dhi[i][32] ^ d[i][31];
			item.ax[i].hi.rem0       = mhi[i][32:16];
			item.ax[i].hi.num_lo     = {mhi[i][15:0], 16'h0000};
			item.ax[i].hi.ovf        = {15'd0, mhi[i][32:16]} >= dm[i];
		end
	end

endmodule
`default_nettype wire

// File: design/rabi_queue.sv
`default_nettype none
module rabi_queue #(
	parameter int DEPTH = rabi_pkg::QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire rabi_pkg::item_t  wdata,
	input  wire logic             pop,
	output logic                  full,
	output logic                  nonempty,
	output rabi_pkg::item_t       rdata
);

	localparam int PW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	rabi_pkg::item_t mem [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_pop;

	assign full     = (count_q == CW'(DEPTH));
	assign nonempty = (count_q != '0);
	assign do_pop   = pop && nonempty;
	assign rdata    = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// File: design/rabi_div.sv
`default_nettype none
module rabi_div (
	input  wire logic        clk,
	input  wire logic [16:0] rem0,
	input  wire logic [31:0] num_lo,
	input  wire logic [31:0] dmag,
	output logic [31:0]      quo
);

	localparam int N = rabi_pkg::DIV_STEPS;

	logic [31:0] rem_s [N+1];
	logic [31:0] lo_s  [N+1];
	logic [31:0] dv_s  [N+1];
	logic [31:0] q_s   [N+1];

	assign rem_s[0] = {15'd0, rem0};
	assign lo_s[0]  = num_lo;
	assign dv_s[0]  = dmag;
	assign q_s[0]   = '0;
	assign quo      = q_s[N];

	// restoring division, one quotient bit per stage
	for (genvar k = 0; k < N; k++) begin : g_step
		logic [32:0] r;
		logic [32:0] sub;
		logic        ge;
		always_comb begin
			r   = {rem_s[k], lo_s[k][31]};
			sub = r - {1'b0, dv_s[k]};
			ge  = r >= {1'b0, dv_s[k]};
		end
		always_ff @(posedge clk) begin
			rem_s[k+1] <= ge ? sub[31:0] : r[31:0];
			lo_s[k+1]  <= {lo_s[k][30:0], 1'b0};
			dv_s[k+1]  <= dv_s[k];
			q_s[k+1]   <= {q_s[k][30:0], ge};
		end
	end

endmodule
`default_nettype wire

// File: design/rabi_back.sv
`default_nettype none
module rabi_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             pop,
	input  wire rabi_pkg::item_t  item,
	output logic                  done,
	output rabi_pkg::out_t        rsp
);

	localparam int N = rabi_pkg::DIV_STEPS;

	typedef struct packed {
		logic signed [31:0] start;
		logic signed [31:0] dir;
		logic               zero;
		logic               in_slab;
		logic               lo_neg;
		logic               lo_ovf;
		logic               hi_neg;
		logic               hi_ovf;
	} side_t;

	side_t [2:0]  side_s [N];
	logic [N-1:0] vld_s;
	logic [31:0]  qlo [3];
	logic [31:0]  qhi [3];

	for (genvar i = 0; i < 3; i++) begin : g_ax
		rabi_div u_div_lo (
			.clk    (clk),
			.rem0   (item.ax[i].lo.rem0),
			.num_lo (item.ax[i].lo.num_lo),
			.dmag   (item.ax[i].dmag),
			.quo    (qlo[i])
		);
		rabi_div u_div_hi (
			.clk    (clk),
			.rem0   (item.ax[i].hi.rem0),
			.num_lo (item.ax[i].hi.num_lo),
			.dmag   (item.ax[i].dmag),
			.quo    (qhi[i])
		);
	end

	// sideband rides alongside the divider stages
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			side_s[0][i].start   <= item.ax[i].start;
			side_s[0][i].dir     <= item.ax[i].dir;
			side_s[0][i].zero    <= item.ax[i].zero;
			side_s[0][i].in_slab <= item.ax[i].in_slab;
			side_s[0][i].lo_neg  <= item.ax[i].lo.neg;
			side_s[0][i].lo_ovf  <= item.ax[i].lo.ovf;
			side_s[0][i].hi_neg  <= item.ax[i].hi.neg;
			side_s[0][i].hi_ovf  <= item.ax[i].hi.ovf;
		end
		for (int k = 1; k < N; k++) begin
			side_s[k] <= side_s[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[N-2:0], pop};
		end
	end

	// slab limits per axis
	logic signed [31:0] ta [3];
	logic signed [31:0] tb [3];
	logic signed [31:0] en_c [3];
	logic signed [31:0] lv_c [3];
	logic               ok_c;

	always_comb begin
		ok_c = 1'b1;
		for (int i = 0; i < 3; i++) begin
			ta[i] = rabi_pkg::sat_param(qlo[i], side_s[N-1][i].lo_neg, side_s[N-1][i].lo_ovf);
			tb[i] = rabi_pkg::sat_param(qhi[i], side_s[N-1][i].hi_neg, side_s[N-1][i].hi_ovf);
			if (side_s[N-1][i].zero) begin
				en_c[i] = rabi_pkg::Q_MIN;
				lv_c[i] = rabi_pkg::Q_MAX;
				if (!side_s[N-1][i].in_slab) ok_c = 1'b0;
			end else begin
				en_c[i] = (ta[i] < tb[i]) ? ta[i] : tb[i];
				lv_c[i] = (ta[i] < tb[i]) ? tb[i] : ta[i];
			end
		end
	end

	logic                      vld_s1;
	logic                      ok_s1;
	logic signed [31:0]        en_s1 [3];
	logic signed [31:0]        lv_s1 [3];
	logic signed [2:0][31:0]   st_s1;
	logic signed [2:0][31:0]   dr_s1;

	always_ff @(posedge clk) begin
		ok_s1 <= ok_c;
		for (int i = 0; i < 3; i++) begin
			en_s1[i] <= en_c[i];
			lv_s1[i] <= lv_c[i];
			st_s1[i] <= side_s[N-1][i].start;
			dr_s1[i] <= side_s[N-1][i].dir;
		end
	end

	// entry and exit reduction
	logic signed [31:0] tmin_c;
	logic signed [31:0] tmax_c;

	always_comb begin
		tmin_c = en_s1[0];
		tmax_c = lv_s1[0];
		for (int i = 1; i < 3; i++) begin
			if (en_s1[i] > tmin_c) tmin_c = en_s1[i];
			if (lv_s1[i] < tmax_c) tmax_c = lv_s1[i];
		end
	end

	logic                    vld_s2;
	logic                    hit_s2;
	logic signed [31:0]      tmin_s2;
	logic signed [2:0][31:0] st_s2;
	logic signed [2:0][31:0] dr_s2;

	always_ff @(posedge clk) begin
		hit_s2  <= ok_s1 && !tmax_c[31] && (tmin_c <= tmax_c);
		tmin_s2 <= tmin_c;
		st_s2   <= st_s1;
		dr_s2   <= dr_s1;
	end

	logic                    vld_s3;
	logic                    hit_s3;
	logic signed [63:0]      pr_s3 [3];
	logic signed [2:0][31:0] st_s3;

	always_ff @(posedge clk) begin
		hit_s3 <= hit_s2;
		st_s3  <= st_s2;
		for (int i = 0; i < 3; i++) begin
			pr_s3[i] <= 64'($signed(dr_s2[i])) * 64'(tmin_s2);
		end
	end

	// floor shift of the product, add start, saturate, zero on a miss
	logic signed [48:0] sum_c [3];
	logic signed [31:0] co_c  [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum_c[i] = 49'($signed(st_s3[i])) + 49'($signed(pr_s3[i][63:16]));
			if (sum_c[i] > 49'(rabi_pkg::Q_MAX)) co_c[i] = rabi_pkg::Q_MAX;
			else if (sum_c[i] < 49'(rabi_pkg::Q_MIN)) co_c[i] = rabi_pkg::Q_MIN;
			else co_c[i] = sum_c[i][31:0];
			if (!hit_s3) co_c[i] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s1 <= vld_s[N-1];
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			done   <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		rsp.hit   <= hit_s3;
		rsp.hit_x <= co_c[0];
		rsp.hit_y <= co_c[1];
		rsp.hit_z <= co_c[2];
	end

endmodule
`default_nettype wire

// File: design/ray_aabb_slab_intersect_core.sv
`default_nettype none
// Ray against axis-aligned box slab test in signed Q16.16. A beat is taken on
// start while busy is low; one result per beat appears on rsp with done high
// for a single cycle, in order. One beat per cycle is sustained: the six
// slab divisions run in fully pipelined 32-stage restoring dividers, one
// quotient bit per stage, and the back end never stalls, so busy only rises
// if the front queue fills, which the always-draining back end does not
// allow. On a miss hit and all coordinates are zero.
module ray_aabb_slab_intersect_core #(
	parameter int QUEUE_DEPTH = rabi_pkg::QUEUE_DEPTH
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire rabi_pkg::in_t   req,
	output logic                 done,
	output rabi_pkg::out_t       rsp
);

	logic             push;
	logic             q_full;
	logic             q_nonempty;
	rabi_pkg::item_t  f_item;
	rabi_pkg::item_t  b_item;

	rabi_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.full   (q_full),
		.push   (push),
		.item   (f_item)
	);

	rabi_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wdata    (f_item),
		.pop      (q_nonempty),
		.full     (q_full),
		.nonempty (q_nonempty),
		.rdata    (b_item)
	);

	rabi_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.pop    (q_nonempty),
		.item   (b_item),
		.done   (done),
		.rsp    (rsp)
	);

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !rsp.hit |-> rsp.hit_x == 32'sd0 && rsp.hit_y == 32'sd0 && rsp.hit_z == 32'sd0)
		else $error("miss result carries a nonzero point");

	a_busy_full: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> q_full)
		else $error("busy raised while the queue has room");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !push)
		else $error("queue written while full");

endmodule
`default_nettype wire
